// ----- hw/rtl/quaternion_smallest_three_decode_macros.svh -----
// ----------------------------------------------------------------------------
// Smallest-three decoder assertion macros
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_SMALLEST_THREE_DECODE_MACROS_SVH
`define QUATERNION_SMALLEST_THREE_DECODE_MACROS_SVH

// same-cycle implication
`define QS3D_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QS3D_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/qs3d_pkg.sv -----
// ----------------------------------------------------------------------------
// qs3d_pkg
// Constants, types and helpers shared by the smallest-three decoder.
// ----------------------------------------------------------------------------
package qs3d_pkg;

  localparam int FIELD_BITS = 15;
  localparam int COMP_W     = 16;

  // field decode: raw * STEP - OFFS, Q.40
  localparam longint unsigned FIELD_MAX_L = (64'd1 << FIELD_BITS) - 64'd1;
  localparam longint unsigned STEP_L =
    ((64'd1414214 << 40) + (FIELD_MAX_L * 64'd1000000) / 64'd2) /
    (FIELD_MAX_L * 64'd1000000);
  localparam longint unsigned OFFS_L =
    ((64'd1 << 40) * 64'd1000000 + 64'd707107) / 64'd1414214;

  localparam int STEP_W = 26;
  localparam logic [STEP_W-1:0] STEP_Q40 = STEP_W'(STEP_L);
  localparam logic [39:0]       OFFS_Q40 = 40'(OFFS_L);

  localparam int PROD_W = FIELD_BITS + STEP_W;  // 41
  localparam int VA_W   = PROD_W + 1;           // signed Q.40
  localparam int MAG_W  = 40;                   // |va| < 2^40
  localparam int MAGX_W = MAG_W + 1;            // after rounding add
  localparam int SQ_SHIFT = 10;                 // Q.40 -> Q.30
  localparam int SA_W   = 30;                   // |Q.30| < 2^30
  localparam int SQ_W   = 2 * SA_W;
  localparam int SUM_W  = 61;
  localparam int ARG_W  = 61;

  localparam logic [SUM_W-1:0] ONE_Q60 = {1'b1, 60'd0};

  // square root
  localparam int X_W        = 62;
  localparam int ROOT_STEPS = X_W / 2;
  localparam int ROOT_W     = 31;
  localparam int REM_W      = 33;

  // front-to-back queue
  localparam int QDEPTH = 8;
  localparam int QPTR_W = 3;
  localparam int QCNT_W = 4;

  // slot codes
  localparam logic [1:0] SLOT_FIRST  = 2'd0;
  localparam logic [1:0] SLOT_SECOND = 2'd1;
  localparam logic [1:0] SLOT_THIRD  = 2'd2;
  localparam logic [1:0] SLOT_FOURTH = 2'd3;

  typedef struct packed {
    logic              clamped;
    logic [1:0]        slot;
    logic [COMP_W-1:0] ra;
    logic [COMP_W-1:0] rb;
    logic [COMP_W-1:0] rc;
  } qs3d_side_t;

  typedef struct packed {
    logic [ARG_W-1:0] arg;
    qs3d_side_t       side;
  } qs3d_entry_t;

  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } qs3d_qstat_t;

  // saturate sign/magnitude to a 16-bit two's complement word
  function automatic logic [COMP_W-1:0] sat_comp(input logic neg,
                                                 input logic [MAGX_W-1:0] mag);
    logic [COMP_W-1:0] res;
    if (neg) begin
      if (mag > MAGX_W'(32768)) res = 16'h8000;
      else                      res = COMP_W'(MAGX_W'(0) - mag);
    end else begin
      if (mag > MAGX_W'(32767)) res = 16'h7FFF;
      else                      res = mag[COMP_W-1:0];
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/qs3d_front.sv -----
// ----------------------------------------------------------------------------
// qs3d_front
// Accepts words, unpacks fields, decodes, squares and forms the root argument.
// ----------------------------------------------------------------------------
module qs3d_front import qs3d_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        in_word_zero,
  input  logic [15:0]        in_word_one,
  input  logic [15:0]        in_word_two,
  input  qs3d_qstat_t        qstat,
  output logic               push,
  output qs3d_entry_t        push_entry
);

  localparam int SH_OUT = 40 - FRAC_BITS;
  localparam logic [MAGX_W-1:0] HALF_OUT = MAGX_W'(1) << (SH_OUT - 1);
  localparam logic [MAGX_W-1:0] HALF_SQ  = MAGX_W'(1) << (SQ_SHIFT - 1);

  logic accept;

  // stage 1: unpacked fields
  logic                        s1_vld_r;
  logic [2:0][FIELD_BITS-1:0]  s1_fld_r;
  logic [1:0]                  s1_slot_r;
  // stage 2: decoded Q.40
  logic                        s2_vld_r;
  logic [2:0][VA_W-1:0]        s2_va_r;
  logic [2:0][VA_W-1:0]        s2_va_nxt;
  logic [1:0]                  s2_slot_r;
  // stage 3: Q.30 magnitudes and output components
  logic                        s3_vld_r;
  logic [2:0][SA_W-1:0]        s3_sa_r;
  logic [2:0][SA_W-1:0]        s3_sa_nxt;
  logic [2:0][COMP_W-1:0]      s3_comp_r;
  logic [2:0][COMP_W-1:0]      s3_comp_nxt;
  logic [1:0]                  s3_slot_r;
  // stage 4: squares
  logic                        s4_vld_r;
  logic [2:0][SQ_W-1:0]        s4_sq_r;
  logic [2:0][SQ_W-1:0]        s4_sq_nxt;
  logic [2:0][COMP_W-1:0]      s4_comp_r;
  logic [1:0]                  s4_slot_r;

  logic [2:0][PROD_W-1:0]      prod;
  logic [2:0][MAG_W-1:0]       mag;
  logic [SUM_W-1:0]            sum;
  logic [2:0]                  inflight;
  logic [QCNT_W:0]             commit;

  assign accept = start && !busy;

  // credits: everything in flight must fit in the queue
  assign inflight = {2'b00, s1_vld_r} + {2'b00, s2_vld_r}
                  + {2'b00, s3_vld_r} + {2'b00, s4_vld_r};
  assign commit   = {1'b0, qstat.count} + (QCNT_W + 1)'(inflight);
  assign busy     = commit >= (QCNT_W + 1)'(QDEPTH);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i]      = PROD_W'(s1_fld_r[i]) * PROD_W'(STEP_Q40);
      s2_va_nxt[i] = {1'b0, prod[i]} - VA_W'(OFFS_Q40);

      mag[i] = s2_va_r[i][VA_W-1] ? MAG_W'(VA_W'(0) - s2_va_r[i])
                                  : s2_va_r[i][MAG_W-1:0];
      s3_sa_nxt[i]   = SA_W'((MAGX_W'(mag[i]) + HALF_SQ) >> SQ_SHIFT);
      s3_comp_nxt[i] = sat_comp(s2_va_r[i][VA_W-1],
                                (MAGX_W'(mag[i]) + HALF_OUT) >> SH_OUT);

      s4_sq_nxt[i] = SQ_W'(s3_sa_r[i]) * SQ_W'(s3_sa_r[i]);
    end
  end

  // valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_fld_r[0] <= {in_word_zero[12:0], in_word_one[15:14]};
      s1_fld_r[1] <= {in_word_one[13:0], in_word_two[15]};
      s1_fld_r[2] <= in_word_two[14:0];
      s1_slot_r   <= in_word_zero[14:13];
    end
    s2_va_r   <= s2_va_nxt;
    s2_slot_r <= s1_slot_r;
    s3_sa_r   <= s3_sa_nxt;
    s3_comp_r <= s3_comp_nxt;
    s3_slot_r <= s2_slot_r;
    s4_sq_r   <= s4_sq_nxt;
    s4_comp_r <= s3_comp_r;
    s4_slot_r <= s3_slot_r;
  end

  // argument = 1 - sum of squares, clamped at zero
  assign sum = SUM_W'(s4_sq_r[0]) + SUM_W'(s4_sq_r[1]) + SUM_W'(s4_sq_r[2]);

  always_comb begin
    push                    = s4_vld_r;
    push_entry.side.clamped = sum > ONE_Q60;
    push_entry.side.slot    = s4_slot_r;
    push_entry.side.ra      = s4_comp_r[0];
    push_entry.side.rb      = s4_comp_r[1];
    push_entry.side.rc      = s4_comp_r[2];
    push_entry.arg          = (sum > ONE_Q60) ? '0 : ARG_W'(ONE_Q60 - sum);
  end

endmodule

// ----- hw/rtl/qs3d_queue.sv -----
// ----------------------------------------------------------------------------
// qs3d_queue
// Short FIFO between the decode front and the root back end.
// ----------------------------------------------------------------------------
`include "quaternion_smallest_three_decode_macros.svh"

module qs3d_queue import qs3d_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  qs3d_entry_t  push_entry,
  input  logic         pop,
  output qs3d_entry_t  head,
  output qs3d_qstat_t  qstat
);

  qs3d_entry_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r;
  logic [QCNT_W-1:0]   cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + QCNT_W'(1);
    if (!push && pop) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

  assign head        = mem_r[rd_ptr_r];
  assign qstat.empty = (cnt_r == '0);
  assign qstat.count = cnt_r;

  `QS3D_ASSERT_IMP(a_no_overflow, push && !pop, cnt_r != QCNT_W'(QDEPTH), "queue overflow")
  `QS3D_ASSERT_IMP(a_no_underflow, pop, cnt_r != '0, "pop from empty queue")
  `QS3D_ASSERT_NXT(a_cnt_up, push && !pop, cnt_r == $past(cnt_r) + QCNT_W'(1), "count lost")
  `QS3D_ASSERT_IMP(a_ptr_match, cnt_r != QCNT_W'(QDEPTH), QPTR_W'(cnt_r) == QPTR_W'(wr_ptr_r - rd_ptr_r), "ptr mismatch")

endmodule

// ----- hw/rtl/qs3d_back.sv -----
// ----------------------------------------------------------------------------
// qs3d_back
// Pipelined square root, rounding and slot insertion of the omitted component.
// ----------------------------------------------------------------------------
module qs3d_back import qs3d_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst_n,
  input  qs3d_qstat_t        qstat,
  input  qs3d_entry_t        head,
  output logic               pop,
  output logic               out_strobe,
  output logic [COMP_W-1:0]  comp_first,
  output logic [COMP_W-1:0]  comp_second,
  output logic [COMP_W-1:0]  comp_third,
  output logic [COMP_W-1:0]  comp_fourth,
  output logic               root_clamped
);

  localparam int SH_ROOT = 30 - FRAC_BITS;

  // one root digit per stage
  logic [ROOT_STEPS-1:0]             st_vld_r;
  logic [ROOT_STEPS-1:0][REM_W-1:0]  st_rem_r;
  logic [ROOT_STEPS-1:0][ROOT_W-1:0] st_q_r;
  logic [ROOT_STEPS-1:0][X_W-1:0]    st_x_r;
  qs3d_side_t                        st_side_r [ROOT_STEPS];

  logic [ROOT_STEPS-1:0][REM_W-1:0]  src_rem;
  logic [ROOT_STEPS-1:0][ROOT_W-1:0] src_q;
  logic [ROOT_STEPS-1:0][X_W-1:0]    src_x;
  qs3d_side_t                        src_side [ROOT_STEPS];
  logic [ROOT_STEPS-1:0][REM_W+2:0]  trial;
  logic [ROOT_STEPS-1:0][REM_W+1:0]  shifted;
  logic [ROOT_STEPS-1:0][REM_W-1:0]  st_rem_nxt;
  logic [ROOT_STEPS-1:0][ROOT_W-1:0] st_q_nxt;
  logic [ROOT_STEPS-1:0][X_W-1:0]    st_x_nxt;

  // round-to-nearest stage
  logic              rd_vld_r;
  logic [ROOT_W-1:0] rd_root_r;
  logic [ROOT_W-1:0] rd_root_nxt;
  qs3d_side_t        rd_side_r;

  logic [31:0]       rmag;
  logic [COMP_W-1:0] root_comp;

  // output register
  logic              out_vld_r;
  logic [COMP_W-1:0] out_c0_r, out_c1_r, out_c2_r, out_c3_r;
  logic [COMP_W-1:0] out_c0_nxt, out_c1_nxt, out_c2_nxt, out_c3_nxt;
  logic              out_clamp_r;

  assign pop = !qstat.empty;

  always_comb begin
    src_rem[0]  = '0;
    src_q[0]    = '0;
    src_x[0]    = {1'b0, head.arg};
    src_side[0] = head.side;
    for (int k = 1; k < ROOT_STEPS; k++) begin
      src_rem[k]  = st_rem_r[k-1];
      src_q[k]    = st_q_r[k-1];
      src_x[k]    = st_x_r[k-1];
      src_side[k] = st_side_r[k-1];
    end
    for (int k = 0; k < ROOT_STEPS; k++) begin
      shifted[k]    = {src_rem[k], src_x[k][X_W-1 -: 2]};
      trial[k]      = {1'b0, shifted[k]} - {3'b000, src_q[k], 2'b01};
      st_rem_nxt[k] = trial[k][REM_W+2] ? shifted[k][REM_W-1:0] : trial[k][REM_W-1:0];
      st_q_nxt[k]   = {src_q[k][ROOT_W-2:0], ~trial[k][REM_W+2]};
      st_x_nxt[k]   = {src_x[k][X_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_vld_r  <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      st_vld_r  <= {st_vld_r[ROOT_STEPS-2:0], pop};
      rd_vld_r  <= st_vld_r[ROOT_STEPS-1];
      out_vld_r <= rd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    st_rem_r <= st_rem_nxt;
    st_q_r   <= st_q_nxt;
    st_x_r   <= st_x_nxt;
    for (int k = 0; k < ROOT_STEPS; k++) begin
      st_side_r[k] <= src_side[k];
    end
  end

  // floor root plus one when remainder exceeds it
  assign rd_root_nxt = st_q_r[ROOT_STEPS-1] +
    ROOT_W'(st_rem_r[ROOT_STEPS-1] > REM_W'(st_q_r[ROOT_STEPS-1]));

  always_ff @(posedge clk) begin
    rd_root_r <= rd_root_nxt;
    rd_side_r <= st_side_r[ROOT_STEPS-1];
  end

  // Q.30 -> FRAC_BITS
  generate
    if (SH_ROOT > 0) begin : g_round
      assign rmag = (32'(rd_root_r) + (32'd1 << (SH_ROOT - 1))) >> SH_ROOT;
    end else begin : g_pass
      assign rmag = 32'(rd_root_r);
    end
  endgenerate

  assign root_comp = sat_comp(1'b0, MAGX_W'(rmag));

  always_comb begin
    out_c0_nxt = rd_side_r.ra;
    out_c1_nxt = rd_side_r.rb;
    out_c2_nxt = rd_side_r.rc;
    out_c3_nxt = root_comp;
    unique case (rd_side_r.slot)
      SLOT_FIRST: begin
        out_c0_nxt = root_comp;
        out_c1_nxt = rd_side_r.ra;
        out_c2_nxt = rd_side_r.rb;
        out_c3_nxt = rd_side_r.rc;
      end
      SLOT_SECOND: begin
        out_c1_nxt = root_comp;
        out_c2_nxt = rd_side_r.rb;
        out_c3_nxt = rd_side_r.rc;
      end
      SLOT_THIRD: begin
        out_c2_nxt = root_comp;
        out_c3_nxt = rd_side_r.rc;
      end
      SLOT_FOURTH: begin
        out_c3_nxt = root_comp;
      end
      default: begin
        out_c3_nxt = root_comp;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_c0_r    <= out_c0_nxt;
    out_c1_r    <= out_c1_nxt;
    out_c2_r    <= out_c2_nxt;
    out_c3_r    <= out_c3_nxt;
    out_clamp_r <= rd_side_r.clamped;
  end

  assign out_strobe   = out_vld_r;
  assign comp_first   = out_c0_r;
  assign comp_second  = out_c1_r;
  assign comp_third   = out_c2_r;
  assign comp_fourth  = out_c3_r;
  assign root_clamped = out_clamp_r;

endmodule

// ----- hw/rtl/quaternion_smallest_three_decode.sv -----
// ----------------------------------------------------------------------------
// quaternion_smallest_three_decode
// 48-bit smallest-three quaternion decoder with a pipelined square root.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a word is three 16-bit packed halves on in_word_zero/one/two. It is
//   taken at a rising edge where start is high and busy is low.
//   Output: each word yields one result. out_strobe is high for exactly one
//   cycle with the four Q2.14 components and out_root_clamped; the receiver
//   cannot hold results off, so nothing downstream ever stalls the block.
//   Path: an accepted word passes the 4 front stages, the queue, the 31 root
//   stages, the rounding register and the output register.
//   Throughput: one word per cycle. The root pipeline retires one entry
//   each cycle; busy only rises if the credit count (queue fill plus front
//   stages in flight) would reach the queue depth, which a steady stream
//   never does.
//   Reset: rst_n low (synchronous) empties the pipeline and the queue;
//   busy is low and out_strobe is low after reset.
//   FRAC_BITS sets the fraction bits of the components (10 to 30).
// ----------------------------------------------------------------------------
module quaternion_smallest_three_decode import qs3d_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        in_word_zero,
  input  logic [15:0]        in_word_one,
  input  logic [15:0]        in_word_two,
  output logic               out_strobe,
  output logic signed [15:0] out_comp_first,
  output logic signed [15:0] out_comp_second,
  output logic signed [15:0] out_comp_third,
  output logic signed [15:0] out_comp_fourth,
  output logic               out_root_clamped
);

  // front -> queue
  logic        push;
  qs3d_entry_t push_entry;
  // queue -> back
  logic        pop;
  qs3d_entry_t head;
  qs3d_qstat_t qstat;

  logic [COMP_W-1:0] c0, c1, c2, c3;

  // unpack, decode, square, sum and clamp
  qs3d_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_word_zero (in_word_zero),
    .in_word_one  (in_word_one),
    .in_word_two  (in_word_two),
    .qstat        (qstat),
    .push         (push),
    .push_entry   (push_entry)
  );

  // decouples front from the root pipeline
  qs3d_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  // digit-per-stage root, rounding and slot insertion
  qs3d_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .qstat        (qstat),
    .head         (head),
    .pop          (pop),
    .out_strobe   (out_strobe),
    .comp_first   (c0),
    .comp_second  (c1),
    .comp_third   (c2),
    .comp_fourth  (c3),
    .root_clamped (out_root_clamped)
  );

  assign out_comp_first  = $signed(c0);
  assign out_comp_second = $signed(c1);
  assign out_comp_third  = $signed(c2);
  assign out_comp_fourth = $signed(c3);

endmodule

// ----- tb/quaternion_smallest_three_decode_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_smallest_three_decode_tb
// Self-checking bench for the 48-bit smallest-three quaternion decoder.
// Directed words hit the field extremes, every slot, a clamped root and the
// ignored top bit. Random words then follow, under three sender idle
// profiles. A scoreboard predicts each result in fixed point and compares it
// field by field.
// ----------------------------------------------------------------------------
module quaternion_smallest_three_decode_tb;

  localparam int FRAC   = 14;     // fraction bits of the components
  localparam int PERIOD = 20;
  localparam int RST_CYCLES = 11;
  localparam int DRAIN_CYCLES = 60;   // outlasts the full pipeline, with margin
  localparam int STALL_LIMIT = 4000;  // idle edges before we call it a hang
  localparam int RAND_PER_PHASE = 310;

  // field decode constants, Q.40: raw * STEP - OFFS
  localparam longint unsigned FMAX = 64'd32767;
  localparam longint unsigned STEP =
    ((64'd1414214 << 40) + (FMAX * 64'd1000000) / 64'd2) / (FMAX * 64'd1000000);
  localparam longint unsigned OFFS =
    ((64'd1 << 40) * 64'd1000000 + 64'd707107) / 64'd1414214;

  typedef struct packed {
    logic             clamped;
    logic [3:0][15:0] comp;
  } quat_t;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts each decoded quaternion and checks results in order
  // --------------------------------------------------------------------------
  class quat_scoreboard;
    quat_t expected_quats[$];
    int    n_fail;
    int    n_checked;
    int    n_clamped;
    int    slot_use[4];

    // round to nearest, ties away from zero
    static function longint round_away(longint x, int s);
      longint unsigned m;
      if (s == 0) return x;
      m = (x < 0) ? longint'(-x) : longint'(x);
      m = (m + (64'd1 << (s - 1))) >> s;
      return (x < 0) ? -longint'(m) : longint'(m);
    endfunction

    // bitwise integer root of a Q.60 value, rounded to nearest Q.30
    static function longint unsigned root_q30(longint unsigned arg);
      longint unsigned x, r, b;
      x = arg;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      if (x > r) r++;
      return r;
    endfunction

    static function logic [15:0] sat16(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
    endfunction

    static function quat_t predict_quat(logic [47:0] w);
      logic [14:0] fa, fb, fc;
      logic [1:0]  slot;
      longint      va, vb, vc, sa, sb, sc, arg, root, ra, rb, rc;
      quat_t       q;
      {fa, fb, fc} = w[44:0];
      slot = w[46:45];   // w[47] is don't-care
      va = longint'(64'(fa) * STEP) - longint'(OFFS);
      vb = longint'(64'(fb) * STEP) - longint'(OFFS);
      vc = longint'(64'(fc) * STEP) - longint'(OFFS);
      // operands rounded to Q.30, squares and sum at Q.60
      sa = round_away(va, 10);
      sb = round_away(vb, 10);
      sc = round_away(vc, 10);
      arg = (64'sd1 <<< 60) - (sa * sa + sb * sb + sc * sc);
      q.clamped = (arg < 0);
      if (arg < 0) arg = 0;
      root = round_away(longint'(root_q30(arg)), 30 - FRAC);
      ra = round_away(va, 40 - FRAC);
      rb = round_away(vb, 40 - FRAC);
      rc = round_away(vc, 40 - FRAC);
      case (slot)
        qs3d_pkg::SLOT_FIRST:  q.comp = {sat16(rc), sat16(rb), sat16(ra), sat16(root)};
        qs3d_pkg::SLOT_SECOND: q.comp = {sat16(rc), sat16(rb), sat16(root), sat16(ra)};
        qs3d_pkg::SLOT_THIRD:  q.comp = {sat16(rc), sat16(root), sat16(rb), sat16(ra)};
        default:               q.comp = {sat16(root), sat16(rc), sat16(rb), sat16(ra)};
      endcase
      return q;
    endfunction

    function void note_word(logic [47:0] w);
      quat_t q;
      q = predict_quat(w);
      expected_quats.push_back(q);
      slot_use[w[46:45]]++;
      if (q.clamped) n_clamped++;
    endfunction

    function void report(string what);
      n_fail++;
      if (n_fail <= 10) $display("%0t MISMATCH: %s", $realtime, what);
    endfunction

    function void check_result(quat_t got);
      quat_t exp_q;
      if (expected_quats.size() == 0) begin
        report($sformatf("unexpected result comps=%h clamped=%b", got.comp, got.clamped));
        return;
      end
      exp_q = expected_quats.pop_front();
      n_checked++;
      for (int i = 0; i < 4; i++)
        if (got.comp[i] !== exp_q.comp[i])
          report($sformatf("component %0d expected %0d got %0d", i,
                           $signed(exp_q.comp[i]), $signed(got.comp[i])));
      if (got.clamped !== exp_q.clamped)
        report($sformatf("root_clamped expected %b got %b", exp_q.clamped, got.clamped));
    endfunction

    function int pending();
      return expected_quats.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and stimulus signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [15:0] in_word_zero = '0;
  logic [15:0] in_word_one = '0;
  logic [15:0] in_word_two = '0;
  logic        busy;
  logic        out_strobe;
  logic signed [15:0] out_comp_first, out_comp_second, out_comp_third, out_comp_fourth;
  logic        out_root_clamped;

  quat_scoreboard sb;
  int words_sent;
  int stall_cycles;

  quaternion_smallest_three_decode #(.FRAC_BITS(FRAC)) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_word_zero     (in_word_zero),
    .in_word_one      (in_word_one),
    .in_word_two      (in_word_two),
    .out_strobe       (out_strobe),
    .out_comp_first   (out_comp_first),
    .out_comp_second  (out_comp_second),
    .out_comp_third   (out_comp_third),
    .out_comp_fourth  (out_comp_fourth),
    .out_root_clamped (out_root_clamped)
  );

  initial begin
    clk = 1'b0;
    forever #(PERIOD / 2) clk = ~clk;
  end

  // results live for one cycle only; sample them at the edge that ends it
  always @(posedge clk) begin
    if (rst_n && out_strobe)
      sb.check_result({out_root_clamped, out_comp_fourth, out_comp_third,
                       out_comp_second, out_comp_first});
  end

  // hang detector: counts edges at which neither side moves a word
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // packed layout: {ignored bit, slot, a, b, c} maps straight onto w0:w1:w2
  function automatic logic [47:0] pack_quat(logic hi, logic [1:0] slot,
                                            logic [14:0] fa, logic [14:0] fb,
                                            logic [14:0] fc);
    return {hi, slot, fa, fb, fc};
  endfunction

  // raw field around the code for zero (16383/16384), +-spread
  function automatic logic [14:0] near_mid(int spread);
    return 15'(16383 + int'($urandom_range(2 * spread)) - spread);
  endfunction

  function automatic logic [14:0] edge_field();
    case ($urandom_range(5))
      0:       return 15'd0;
      1:       return 15'd1;
      2:       return 15'd16383;
      3:       return 15'd16384;
      4:       return 15'd32766;
      default: return 15'd32767;
    endcase
  endfunction

  function automatic logic [47:0] random_quat();
    logic        hi;
    logic [1:0]  slot;
    int          pick;
    hi = 1'($urandom);
    slot = 2'($urandom);
    pick = $urandom_range(9);
    case (pick)
      // uniform fields: sum of squares spans 0..1.5, so words near the corners clamp
      0, 1, 2, 3: return pack_quat(hi, slot, 15'($urandom), 15'($urandom), 15'($urandom));
      // small components: well inside the unit sphere, varied root
      4, 5:       return pack_quat(hi, slot, near_mid(8000), near_mid(8000), near_mid(8000));
      // one field from the edge set (an extreme or the zero code) next to two moderate ones
      6:          return pack_quat(hi, slot, edge_field(), near_mid(12000), near_mid(12000));
      7:          return pack_quat(hi, slot, edge_field(), edge_field(), edge_field());
      default:    return {16'($urandom), 16'($urandom), 16'($urandom)};
    endcase
  endfunction

  // present one word and hold it until taken; optional idle gap first
  task automatic drive_word(logic [47:0] w, int idle_pct);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    {in_word_zero, in_word_one, in_word_two} <= w;
    do @(posedge clk); while (busy);
    sb.note_word(w);
    words_sent++;
  endtask

  // sender holds off until every result is back
  task automatic drain();
    start <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  initial begin
    logic [47:0] directed[$];
    int          n_directed;
    int          idle_pct;
    sb = new();
    words_sent = 0;
    stall_cycles = 0;

    rst_n <= 1'b0;
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: each slot with all-min (clamped), all-max (clamped), all-zero
    for (int s = 0; s < 4; s++) begin
      directed.push_back(pack_quat(1'b0, 2'(s), 15'd0, 15'd0, 15'd0));
      directed.push_back(pack_quat(1'b0, 2'(s), 15'd32767, 15'd32767, 15'd32767));
      directed.push_back(pack_quat(1'b0, 2'(s), 15'd16384, 15'd16383, 15'd16384));
    end
    // ignored top bit must not change the result
    directed.push_back(pack_quat(1'b1, 2'd2, 15'd16384, 15'd16383, 15'd16384));
    directed.push_back(pack_quat(1'b1, 2'd1, 15'd0, 15'd32767, 15'd16383));
    // one extreme alone: root near 0.707
    directed.push_back(pack_quat(1'b0, 2'd0, 15'd0, 15'd16384, 15'd16383));
    directed.push_back(pack_quat(1'b0, 2'd3, 15'd16383, 15'd16384, 15'd32767));
    // two extremes: sum of squares right at 1.0, either side of the clamp
    directed.push_back(pack_quat(1'b0, 2'd1, 15'd0, 15'd32767, 15'd16384));
    directed.push_back(pack_quat(1'b0, 2'd2, 15'd1, 15'd32766, 15'd16383));
    directed.push_back(pack_quat(1'b0, 2'd3, 15'd32767, 15'd16383, 15'd0));
    // all-ones, all-zero and alternating-bit bus words
    directed.push_back(48'hFFFF_FFFF_FFFF);
    directed.push_back(48'h0000_0000_0000);
    directed.push_back(48'h5555_AAAA_5555);
    n_directed = directed.size();
    foreach (directed[i]) drive_word(directed[i], 31);
    drain();

    // random phases: sender idles 31%, then 49%, then back to back
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 31 : (ph == 1) ? 49 : 0;
      for (int i = 0; i < RAND_PER_PHASE; i++) drive_word(random_quat(), idle_pct);
      drain();
    end

    // let anything stray come out before closing the books
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() > 0) begin
      sb.n_fail++;
      $display("%0d expected results never arrived", sb.pending());
    end

    $display("Sent %0d words (%0d directed, rest random over three idle mixes), %0d checked.",
             words_sent, n_directed, sb.n_checked);
    $display("Slots 0..3 used %0d/%0d/%0d/%0d times; %0d roots clamped; %0d mismatches.",
             sb.slot_use[0], sb.slot_use[1], sb.slot_use[2], sb.slot_use[3],
             sb.n_clamped, sb.n_fail);
    if (sb.n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/qs3d_pkg.sv
hw/rtl/qs3d_front.sv
hw/rtl/qs3d_queue.sv
hw/rtl/qs3d_back.sv
hw/rtl/quaternion_smallest_three_decode.sv
tb/quaternion_smallest_three_decode_tb.sv
